>>> sv/tap_hold_key_table_macros.svh
// Assertion macros used by the file that checks the table.
`ifndef TAP_HOLD_KEY_TABLE_MACROS_SVH
`define TAP_HOLD_KEY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define THK_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tap_hold_key_table assertion failed");
`define THK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tap_hold_key_table assertion failed");
`else
`define THK_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define THK_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/thk_pkg.sv
package thk_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int TIME_BITS_DEF  = 16;
    localparam int WORD_TIME_BITS = 16;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ARM   = 3'd1;
    localparam logic [2:0] OP_TAP   = 3'd2;
    localparam logic [2:0] OP_HOLD  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]                opcode;
        logic [1:0]                input_kind;
        logic [7:0]                key_code;
        logic [WORD_TIME_BITS-1:0] hold_threshold;
        logic [WORD_TIME_BITS-1:0] time_delta;
    } t_in_word;

    typedef struct packed {
        logic answer;
        logic found;
        logic dropped;
    } t_out_word;

    // Request token that walks down the row of slot cells.
    typedef struct packed {
        logic                      valid;
        logic [2:0]                op;
        logic                      fill;       // second pass of an arm that missed
        logic [1:0]                kind;
        logic [7:0]                key;
        logic [WORD_TIME_BITS-1:0] thr;
        logic [WORD_TIME_BITS-1:0] dt;
        logic                      found;
        logic                      answer;
        logic                      free_seen;
        logic                      claimed;
    } t_tok;

endpackage

>>> sv/thk_cell.sv
module thk_cell #(
    parameter int TIME_BITS = thk_pkg::TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  thk_pkg::t_tok i_tok,
    output thk_pkg::t_tok o_tok
);
    import thk_pkg::*;

    localparam int XW = (TIME_BITS > WORD_TIME_BITS) ? TIME_BITS : WORD_TIME_BITS;

    logic                 r_valid, n_valid;
    logic [1:0]           r_kind, n_kind;
    logic [7:0]           r_key, n_key;
    logic [TIME_BITS-1:0] r_thr, n_thr;
    logic [TIME_BITS-1:0] r_el, n_el;
    t_tok                 r_tok, n_tok;

    logic [XW-1:0]        thr_x, dt_x;
    logic [TIME_BITS-1:0] thr_m, dt_m, el_sat;
    logic [TIME_BITS:0]   el_sum;
    logic                 match, hit;

    always_comb begin
        thr_x  = XW'(i_tok.thr);
        dt_x   = XW'(i_tok.dt);
        thr_m  = thr_x[TIME_BITS-1:0];
        dt_m   = dt_x[TIME_BITS-1:0];
        el_sum = {1'b0, r_el} + {1'b0, dt_m};
        el_sat = el_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : el_sum[TIME_BITS-1:0];
        match  = r_valid && (r_kind == i_tok.kind) && (r_key == i_tok.key);
        hit    = (i_tok.op == OP_TAP) ? (r_el < r_thr) : (r_el >= r_thr);

        n_valid = r_valid;
        n_kind  = r_kind;
        n_key   = r_key;
        n_thr   = r_thr;
        n_el    = r_el;
        n_tok   = i_tok;

        if (i_tok.valid) begin
            case (i_tok.op)
                OP_TICK: begin
                    if (r_valid) begin
                        n_el = el_sat;
                    end
                end
                OP_ARM: begin
                    if (i_tok.fill) begin
                        // The first empty slot on the second pass takes the entry.
                        if (!r_valid && !i_tok.claimed) begin
                            n_valid       = 1'b1;
                            n_kind        = i_tok.kind;
                            n_key         = i_tok.key;
                            n_thr         = thr_m;
                            n_el          = '0;
                            n_tok.claimed = 1'b1;
                        end
                    end else if (match) begin
                        n_tok.found = 1'b1;
                        n_thr       = thr_m;
                        n_el        = '0;
                    end else if (!r_valid) begin
                        n_tok.free_seen = 1'b1;
                    end
                end
                OP_TAP, OP_HOLD: begin
                    if (match) begin
                        n_tok.found = 1'b1;
                        if (hit) begin
                            n_tok.answer = 1'b1;
                            n_valid      = 1'b0;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
        r_kind <= n_kind;
        r_key  <= n_key;
        r_thr  <= n_thr;
        r_el   <= n_el;
    end

    assign o_tok = r_tok;

endmodule

>>> sv/tap_hold_key_table.sv
// An accepted word's token passes through the ENTRIES slot cells, then the parked result
// register and the output register; an arm that matches no slot but sees a free one first
// walks the row a second time. The next word is taken only once the last result has moved
// to the output register; the request token walks one slot cell per cycle.
// Reset (synchronous, active low) empties the table and clears all handshakes.
`include "tap_hold_key_table_macros.svh"

module tap_hold_key_table #(
    parameter int ENTRIES   = thk_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = thk_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  thk_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output thk_pkg::t_out_word o_out_word
);
    import thk_pkg::*;

    // The table is a row of slot cells. A request becomes a token that enters the
    // first cell when the word is accepted and moves one cell per cycle. Each cell
    // compares the token against its own entry and updates itself: a tick ages
    // the entry, an arm re-arms or fills it, a query may remove it, a clear empties it.
    // Entries are unique by kind and key, so at most one cell matches any request.

    // An arm that matches nothing only learns at the end of the row whether a
    // free slot exists. If one does, it runs a second pass in which the first
    // empty cell claims the entry, which gives the lowest free slot.

    t_tok tok [ENTRIES+1];
    t_tok tail;
    logic accept;
    logic launch;

    logic      r_busy, n_busy;
    logic      r_fin_v, n_fin_v;
    t_out_word r_fin, n_fin;
    logic      r_out_v, n_out_v;
    t_out_word r_out, n_out;

    assign accept = i_in_valid && o_in_ready;
    assign tail   = tok[ENTRIES];
    assign launch = tail.valid && (tail.op == OP_ARM) && !tail.fill && !tail.found
                    && tail.free_seen;

    // Head of the row: a fresh word, or the second pass of a missed arm.
    always_comb begin
        if (launch) begin
            tok[0]         = tail;
            tok[0].fill    = 1'b1;
            tok[0].claimed = 1'b0;
        end else begin
            tok[0]           = '0;
            tok[0].valid     = accept;
            tok[0].op        = i_in_word.opcode;
            tok[0].kind      = i_in_word.input_kind;
            tok[0].key       = i_in_word.key_code;
            tok[0].thr       = i_in_word.hold_threshold;
            tok[0].dt        = i_in_word.time_delta;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        thk_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[g]),
            .o_tok  (tok[g+1])
        );
    end

    // The finished token is parked until the output register is free, so the
    // row itself never stalls.
    always_comb begin
        n_busy  = r_busy;
        n_fin_v = r_fin_v;
        n_fin   = r_fin;
        n_out_v = r_out_v;
        n_out   = r_out;

        if (accept) begin
            n_busy = 1'b1;
        end

        if (tail.valid && !launch) begin
            n_fin_v       = 1'b1;
            n_fin.answer  = tail.answer;
            n_fin.found   = tail.found;
            n_fin.dropped = (tail.op == OP_ARM) && !tail.fill && !tail.found
                            && !tail.free_seen;
        end

        if (r_fin_v && (!r_out_v || i_out_ready)) begin
            n_out_v = 1'b1;
            n_out   = r_fin;
            n_fin_v = 1'b0;
            n_busy  = 1'b0;
        end else if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_fin_v <= n_fin_v;
            r_out_v <= n_out_v;
        end
        r_fin <= n_fin;
        r_out <= n_out;
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    // Only one word is ever inside the block.
    `THK_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, accept, !o_in_ready)
    // A parked result always belongs to the word in flight.
    `THK_ASSERT_NOW(a_fin_busy, i_clk, i_rst_n, r_fin_v, r_busy)
    // A positive answer removes an entry that was found.
    `THK_ASSERT_NOW(a_answer_found, i_clk, i_rst_n, r_out_v && r_out.answer, r_out.found)
    // A dropped arm found neither a match nor a free slot.
    `THK_ASSERT_NOW(a_drop_alone, i_clk, i_rst_n, r_out_v && r_out.dropped,
        !r_out.found && !r_out.answer)

endmodule

>>> dv/tap_hold_key_table_tb.sv
`timescale 1ns / 100ps

module tap_hold_key_table_tb;
    import thk_pkg::*;

    localparam int N_SLOTS         = ENTRIES_DEF;
    localparam int TBITS           = TIME_BITS_DEF;
    localparam int RANDOM_WORDS    = 900;
    localparam int POOL_SIZE       = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 3000;
    // A missed arm walks the slot row twice, so this covers the slowest word.
    localparam int SETTLE_CYCLES   = 2 * N_SLOTS + 4;

    // The opcode field has three encodings that the table does not use.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Result words whose value is obvious without tracking the table.
    localparam t_out_word RES_NONE  = '{answer: 1'b0, found: 1'b0, dropped: 1'b0};
    localparam t_out_word RES_FOUND = '{answer: 1'b0, found: 1'b1, dropped: 1'b0};
    localparam t_out_word RES_HIT   = '{answer: 1'b1, found: 1'b1, dropped: 1'b0};
    localparam t_out_word RES_DROP  = '{answer: 1'b0, found: 1'b0, dropped: 1'b1};

    localparam bit BY_HAND  = 1'b1;
    localparam bit BY_TABLE = 1'b0;

    typedef struct {
        t_in_word  word;
        bit        by_hand;
        t_out_word result;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    // Travels with the word on the input port: when set, the result is the
    // hand-typed value instead of the one the shadow table works out.
    bit        word_by_hand = 1'b0;
    t_out_word hand_result  = RES_NONE;

    t_out_word answers_due[$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    bit        hold_off_req = 1'b0;

    t_row      directed[$];
    logic [1:0] pool_kind [POOL_SIZE];
    logic [7:0] pool_key  [POOL_SIZE];

    // Shadow copy of the key table, updated once per accepted word.
    logic             tbl_used    [N_SLOTS] = '{default: 1'b0};
    logic [1:0]       tbl_kind    [N_SLOTS];
    logic [7:0]       tbl_key     [N_SLOTS];
    logic [TBITS-1:0] tbl_thr     [N_SLOTS];
    logic [TBITS-1:0] tbl_elapsed [N_SLOTS];

    tap_hold_key_table uut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Applies one word to the shadow table and returns the result word it
    // should produce.
    function automatic t_out_word table_response(input t_in_word w);
        t_out_word        r;
        int               hit_slot;
        int               free_slot;
        logic [TBITS:0]   sum;
        logic [TBITS-1:0] thr;
        logic [TBITS-1:0] dt;
        logic             met;
        r         = RES_NONE;
        hit_slot  = -1;
        free_slot = -1;
        thr       = w.hold_threshold[TBITS-1:0];
        dt        = w.time_delta[TBITS-1:0];
        // The first match wins, and an arm fills the lowest free slot.
        for (int i = 0; i < N_SLOTS; i++) begin
            if (hit_slot < 0 && tbl_used[i] && tbl_kind[i] == w.input_kind
                    && tbl_key[i] == w.key_code)
                hit_slot = i;
            if (free_slot < 0 && !tbl_used[i])
                free_slot = i;
        end
        case (w.opcode)
            OP_TICK: begin
                // Elapsed time saturates instead of wrapping.
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (tbl_used[i]) begin
                        sum = {1'b0, tbl_elapsed[i]} + {1'b0, dt};
                        tbl_elapsed[i] = sum[TBITS] ? '1 : sum[TBITS-1:0];
                    end
                end
            end
            OP_ARM: begin
                if (hit_slot >= 0) begin
                    r.found               = 1'b1;
                    tbl_thr[hit_slot]     = thr;
                    tbl_elapsed[hit_slot] = '0;
                end else if (free_slot >= 0) begin
                    tbl_used[free_slot]    = 1'b1;
                    tbl_kind[free_slot]    = w.input_kind;
                    tbl_key[free_slot]     = w.key_code;
                    tbl_thr[free_slot]     = thr;
                    tbl_elapsed[free_slot] = '0;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            OP_TAP, OP_HOLD: begin
                if (hit_slot >= 0) begin
                    r.found = 1'b1;
                    if (w.opcode == OP_TAP)
                        met = tbl_elapsed[hit_slot] < tbl_thr[hit_slot];
                    else
                        met = tbl_elapsed[hit_slot] >= tbl_thr[hit_slot];
                    if (met) begin
                        r.answer           = 1'b1;
                        tbl_used[hit_slot] = 1'b0;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < N_SLOTS; i++)
                    tbl_used[i] = 1'b0;
            end
            default: begin
                // Spare opcodes leave the table alone and answer all zero.
            end
        endcase
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input logic [2:0] op, input logic [1:0] kind,
                                    input logic [7:0] key, input logic [15:0] thr,
                                    input logic [15:0] dt, input bit by_hand,
                                    input t_out_word result);
        t_row r;
        r.word.opcode         = op;
        r.word.input_kind     = kind;
        r.word.key_code       = key;
        r.word.hold_threshold = thr;
        r.word.time_delta     = dt;
        r.by_hand             = by_hand;
        r.result              = result;
        directed              = {directed, r};
    endfunction

    // Random words mostly hit a small pool of keys so that arms, queries and
    // drops meet each other; the rest use any kind and key.
    function automatic void random_word(output t_in_word w);
        logic [63:0] noise;
        int unsigned roll;
        int unsigned pick;
        noise = {$urandom, $urandom};
        w     = noise[$bits(t_in_word)-1:0];
        roll  = $urandom_range(99);
        if (roll < 24)
            w.opcode = OP_TICK;
        else if (roll < 50)
            w.opcode = OP_ARM;
        else if (roll < 70)
            w.opcode = OP_TAP;
        else if (roll < 90)
            w.opcode = OP_HOLD;
        else if (roll < 94)
            w.opcode = OP_CLEAR;
        else
            w.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if ($urandom_range(9) != 0) begin
            pick         = $urandom_range(POOL_SIZE - 1);
            w.input_kind = pool_kind[pick];
            w.key_code   = pool_key[pick];
        end
        // Thresholds and deltas are mostly small so that taps and holds both
        // happen; the full-range ones drive elapsed times into saturation.
        case ($urandom_range(9))
            0:       w.hold_threshold = '0;
            1, 2:    ;
            default: w.hold_threshold = 16'($urandom_range(300));
        endcase
        case ($urandom_range(9))
            0:       w.time_delta = '0;
            1:       ;
            default: w.time_delta = 16'($urandom_range(120));
        endcase
    endfunction

    // Offers one word from the falling edge on and returns at the rising edge
    // that takes it. Valid stays high, so back-to-back calls form a burst.
    task automatic push_word(input t_in_word w, input bit by_hand, input t_out_word result);
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_in_word    = w;
        word_by_hand = by_hand;
        hand_result  = result;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        while (answers_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic compare_bit(input string what, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Both handshakes are observed at the rising edge, where the inputs have
    // been steady since the falling edge. Each accepted input word advances
    // the shadow table; each accepted result word retires the oldest entry.
    always @(posedge i_clk) begin : handshake_monitor
        t_out_word want;
        logic      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                moved       = 1'b1;
                want        = table_response(i_in_word);
                answers_due = {answers_due, (word_by_hand ? hand_result : want)};
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (answers_due.size() == 0) begin
                    $display("%0t: result word %b arrived with none expected, expected none",
                             $time, o_out_word);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    compare_bit("answer", want.answer, o_out_word.answer);
                    compare_bit("found", want.found, o_out_word.found);
                    compare_bit("dropped", want.dropped, o_out_word.dropped);
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // The result side alternates stretches of random stalls with stretches of
    // full readiness, and takes one long break when the stimulus asks for it.
    initial begin : result_sink
        int unsigned stretch;
        int unsigned duty;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            stretch = $urandom_range(4, 60);
            duty    = ($urandom_range(3) == 0) ? 100 : $urandom_range(20, 90);
            repeat (stretch) begin
                @(negedge i_clk);
                i_out_ready = ($urandom_range(99) < duty);
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    initial begin : watchdog
        @(posedge i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_in_word w;
        int       sent;
        int       burst;
        bit       stall_done;
        bit       drain_done;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: empty table, re-arm, zero threshold, full table,
        // saturation of elapsed time, failed query, spare opcodes and clear.
        add_row(OP_TAP,   2'd0, 8'h00, 16'h0000, 16'h0000, BY_HAND, RES_NONE);
        add_row(OP_HOLD,  2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, BY_HAND, RES_NONE);
        add_row(OP_TICK,  2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, BY_HAND, RES_NONE);
        add_row(OP_ARM,   2'd3, 8'hFF, 16'hFFFF, 16'h0000, BY_HAND, RES_NONE);
        add_row(OP_ARM,   2'd3, 8'hFF, 16'h0000, 16'h0000, BY_HAND, RES_FOUND);
        // Zero elapsed meets a zero threshold, so this is a hold.
        add_row(OP_HOLD,  2'd3, 8'hFF, 16'h0000, 16'h0000, BY_HAND, RES_HIT);
        add_row(OP_TAP,   2'd3, 8'hFF, 16'h0000, 16'h0000, BY_HAND, RES_NONE);
        // Eight arms fill the table; the same key under two kinds is two entries.
        add_row(OP_ARM,   2'd1, 8'h01, 16'hFFFF, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd2, 8'h01, 16'h0003, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd0, 8'h80, 16'h0000, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd1, 8'h02, 16'h8000, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd2, 8'h7F, 16'h0001, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd3, 8'h55, 16'h00FF, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd0, 8'hAA, 16'h0002, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd1, 8'h03, 16'h7FFF, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_ARM,   2'd2, 8'hFE, 16'h0000, 16'h0000, BY_HAND, RES_DROP);
        add_row(OP_TAP,   2'd2, 8'h01, 16'h0000, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_TICK,  2'd0, 8'h00, 16'h0000, 16'hFFFF, BY_TABLE, RES_NONE);
        add_row(OP_TICK,  2'd0, 8'h00, 16'h0000, 16'h0001, BY_TABLE, RES_NONE);
        add_row(OP_HOLD,  2'd1, 8'h01, 16'h0000, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_TAP,   2'd1, 8'h02, 16'h0000, 16'h0000, BY_TABLE, RES_NONE);
        add_row(OP_SPARE_FIRST, 2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, BY_HAND, RES_NONE);
        add_row(OP_SPARE_LAST, 2'd1, 8'h03, 16'h0000, 16'h0000, BY_HAND, RES_NONE);
        add_row(OP_CLEAR, 2'd0, 8'h00, 16'h0000, 16'h0000, BY_HAND, RES_NONE);
        add_row(OP_HOLD,  2'd0, 8'h80, 16'h0000, 16'h0000, BY_HAND, RES_NONE);

        foreach (directed[n])
            push_word(directed[n].word, directed[n].by_hand, directed[n].result);
        idle_input(1);
        wait_for_results();

        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_kind[p] = 2'($urandom_range(3));
            pool_key[p]  = 8'($urandom_range(255));
        end

        // Random bursts. Once, the result side takes a long break while a
        // full burst keeps offering words, so the block backs up into its
        // input. Later, the input waits for every result before going on.
        sent       = 0;
        stall_done = 1'b0;
        drain_done = 1'b0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 40);
            if (!stall_done && sent >= 300) begin
                stall_done   = 1'b1;
                hold_off_req = 1'b1;
                burst        = 40;
            end
            repeat (burst) begin
                random_word(w);
                push_word(w, BY_TABLE, RES_NONE);
                sent++;
            end
            if (!drain_done && sent >= 600) begin
                drain_done = 1'b1;
                idle_input(1);
                wait_for_results();
            end else if ($urandom_range(3) != 0) begin
                idle_input($urandom_range(1, 12));
            end
            // Let the key pool drift so that stale entries pile up.
            if ($urandom_range(3) == 0) begin
                burst            = $urandom_range(POOL_SIZE - 1);
                pool_kind[burst] = 2'($urandom_range(3));
                pool_key[burst]  = 8'($urandom_range(255));
            end
        end

        idle_input(1);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
